// ===== rtl/cdrs_pkg.sv =====
// ----------------------------------------------------------------------------
// cdrs_pkg
// Shared types, constants and microprogram for the clock ratio search.
// ----------------------------------------------------------------------------
`default_nettype none

package cdrs_pkg;

    localparam int RATE_W   = 32;
    localparam int TARGET_W = 33;
    localparam int PLL_W    = 30;
    localparam int MULT_W   = 6;
    localparam int DIV_W    = 10;
    localparam int PLLP1_W  = 13;
    localparam int DIVP1_W  = 17;
    localparam int STEP_W   = 3;
    localparam int CNT_W    = 5;
    localparam int OUT_W    = 48;

    localparam logic [PLL_W-1:0]  PLL_REF_HZ   = PLL_W'(25000000);
    localparam logic [MULT_W-1:0] MULT_LOW     = MULT_W'(24);
    localparam logic [MULT_W-1:0] MULT_HIGH    = MULT_W'(36);
    localparam logic [PLL_W-1:0]  PLL_START_HZ = PLL_W'(25000000 * 24);
    localparam logic [PLL_W-1:0]  DIV_LOW      = PLL_W'(8);
    localparam logic [PLL_W-1:0]  DIV_HIGH     = PLL_W'(900);
    localparam logic [CNT_W-1:0]  DIV_LAST     = CNT_W'(PLL_W - 1);
    localparam logic [PLLP1_W-1:0] PLLP1_OFFSET = PLLP1_W'(512);
    localparam logic [DIVP1_W-1:0] DIVP1_OFFSET = DIVP1_W'(512);

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_LOAD     = 3'd1,
        ACT_DIV_INIT = 3'd2,
        ACT_DIV_STEP = 3'd3,
        ACT_INC_MULT = 3'd4,
        ACT_FAIL     = 3'd5,
        ACT_PASS     = 3'd6
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER     = 3'd0,
        COND_IN_VALID  = 3'd1,
        COND_ZERO      = 3'd2,
        COND_DIV_DONE  = 3'd3,
        COND_MATCH     = 3'd4,
        COND_MULT_MORE = 3'd5,
        COND_OUT_FREE  = 3'd6
    } cond_t;

    localparam logic [STEP_W-1:0] S_WAIT  = STEP_W'(0);
    localparam logic [STEP_W-1:0] S_ZERO  = STEP_W'(1);
    localparam logic [STEP_W-1:0] S_DINIT = STEP_W'(2);
    localparam logic [STEP_W-1:0] S_DSTEP = STEP_W'(3);
    localparam logic [STEP_W-1:0] S_CHECK = STEP_W'(4);
    localparam logic [STEP_W-1:0] S_NEXT  = STEP_W'(5);
    localparam logic [STEP_W-1:0] S_FAIL  = STEP_W'(6);
    localparam logic [STEP_W-1:0] S_PASS  = STEP_W'(7);

    typedef struct packed {
        act_t              act;
        cond_t             cond;
        logic [STEP_W-1:0] target;
        logic              hold;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic zero;
        logic div_done;
        logic match;
        logic mult_more;
        logic out_free;
    } flags_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            case (step)
                S_WAIT:  w = '{ACT_LOAD,     COND_IN_VALID,  S_ZERO,  1'b1};
                S_ZERO:  w = '{ACT_NONE,     COND_ZERO,      S_FAIL,  1'b0};
                S_DINIT: w = '{ACT_DIV_INIT, COND_NEVER,     S_WAIT,  1'b0};
                S_DSTEP: w = '{ACT_DIV_STEP, COND_DIV_DONE,  S_CHECK, 1'b1};
                S_CHECK: w = '{ACT_NONE,     COND_MATCH,     S_PASS,  1'b0};
                S_NEXT:  w = '{ACT_INC_MULT, COND_MULT_MORE, S_DINIT, 1'b0};
                S_FAIL:  w = '{ACT_FAIL,     COND_OUT_FREE,  S_WAIT,  1'b1};
                S_PASS:  w = '{ACT_PASS,     COND_OUT_FREE,  S_WAIT,  1'b1};
                default: w = '{ACT_NONE,     COND_NEVER,     S_WAIT,  1'b0};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/clock_divider_ratio_search.sv =====
// ----------------------------------------------------------------------------
// clock_divider_ratio_search
// Finds the first PLL multiplier 24..36 whose 25 MHz multiple divided by twice
// the sample rate leaves no remainder and a quotient in 8..900, and encodes both values.
// ----------------------------------------------------------------------------
// Search: a zero rate fails without any division; otherwise each multiplier
//   tried runs one restoring division over the 30 PLL bits, until the first
//   match or until all 13 fail; a busy output side holds it at its result step.
// Throughput: one item at a time; the next item is taken once the sequencer
//   is back at its wait step, which it reaches at the edge that registers the result.
// Reset: asynchronous, clears the step counter and the output valid flag.
`default_nettype none

module clock_divider_ratio_search
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [cdrs_pkg::RATE_W-1:0]  s_tdata,   // sample_rate_hz[31:0]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [cdrs_pkg::OUT_W-1:0]        m_tdata,   // pll_multiplier[5:0],
                                                         // output_divider[15:6],
                                                         // pll_p1[28:16],
                                                         // divider_p1[45:29], zero pad
    output logic [0:0]                        m_tuser    // status[0]
);
    import cdrs_pkg::*;

    ctrl_t             ctrl;
    flags_t            flags;
    logic              cond_hit;
    logic [STEP_W-1:0] step;

    logic [TARGET_W-1:0] target_reg;
    logic [PLL_W-1:0]    pll_reg;
    logic [MULT_W-1:0]   mult_reg;
    logic [TARGET_W-1:0] rem_reg;
    logic [PLL_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic                status_reg;
    logic [MULT_W-1:0]   res_mult_reg;
    logic [DIV_W-1:0]    res_div_reg;
    logic [PLLP1_W-1:0]  res_pllp1_reg;
    logic [DIVP1_W-1:0]  res_divp1_reg;

    logic [TARGET_W:0]   shifted;
    logic [TARGET_W:0]   trial;
    logic [PLLP1_W-1:0]  pllp1_val;
    logic [DIVP1_W-1:0]  divp1_val;

    cdrs_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .ctrl     (ctrl),
        .cond_hit (cond_hit),
        .step     (step)
    );

    assign s_tready = (step == S_WAIT);

    assign shifted = {rem_reg, quo_reg[PLL_W-1]};
    assign trial   = shifted - {1'b0, target_reg};

    assign pllp1_val = {mult_reg, 7'b0} - PLLP1_OFFSET;
    assign divp1_val = {quo_reg[DIV_W-1:0], 7'b0} - DIVP1_OFFSET;

    always_comb
    begin
        flags.in_valid  = s_tvalid;
        flags.zero      = (target_reg == '0);
        flags.div_done  = (cnt_reg == DIV_LAST);
        flags.match     = (rem_reg == '0) && (quo_reg >= DIV_LOW) && (quo_reg <= DIV_HIGH);
        flags.mult_more = (mult_reg != MULT_HIGH);
        flags.out_free  = !out_valid_reg || m_tready;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.act)
            ACT_LOAD:
            begin
                if (cond_hit)
                begin
                    target_reg <= {s_tdata, 1'b0};
                    pll_reg    <= PLL_START_HZ;
                    mult_reg   <= MULT_LOW;
                end
            end
            ACT_DIV_INIT:
            begin
                rem_reg <= '0;
                quo_reg <= pll_reg;
                cnt_reg <= '0;
            end
            ACT_DIV_STEP:
            begin
                if (!trial[TARGET_W])
                begin
                    rem_reg <= trial[TARGET_W-1:0];
                    quo_reg <= {quo_reg[PLL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[TARGET_W-1:0];
                    quo_reg <= {quo_reg[PLL_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ACT_INC_MULT:
            begin
                pll_reg  <= pll_reg + PLL_REF_HZ;
                mult_reg <= mult_reg + MULT_W'(1);
            end
            ACT_FAIL:
            begin
                if (cond_hit)
                begin
                    status_reg    <= 1'b1;
                    res_mult_reg  <= '0;
                    res_div_reg   <= '0;
                    res_pllp1_reg <= '0;
                    res_divp1_reg <= '0;
                end
            end
            ACT_PASS:
            begin
                if (cond_hit)
                begin
                    status_reg    <= 1'b0;
                    res_mult_reg  <= mult_reg;
                    res_div_reg   <= quo_reg[DIV_W-1:0];
                    res_pllp1_reg <= pllp1_val;
                    res_divp1_reg <= divp1_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cond_hit && (ctrl.act == ACT_FAIL || ctrl.act == ACT_PASS))
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = status_reg;
    assign m_tdata    = {2'b0, res_divp1_reg, res_pllp1_reg, res_div_reg, res_mult_reg};

    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step == S_DSTEP) |-> (mult_reg >= MULT_LOW && mult_reg <= MULT_HIGH))
        else $error("multiplier out of range during division");

    a_pass_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[5:0] >= MULT_LOW && m_tdata[5:0] <= MULT_HIGH
            && m_tdata[15:6] >= 10'd8 && m_tdata[15:6] <= 10'd900))
        else $error("passing result has fields out of range");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("failing result has nonzero fields");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (step == S_ZERO && mult_reg == MULT_LOW
            && pll_reg == PLL_START_HZ))
        else $error("accepted item did not start the search");

endmodule

`default_nettype wire

// ===== rtl/cdrs_seq.sv =====
// ----------------------------------------------------------------------------
// cdrs_seq
// Step counter and microprogram ROM with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module cdrs_seq
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cdrs_pkg::flags_t       flags,
    output cdrs_pkg::ctrl_t             ctrl,
    output logic                        cond_hit,
    output logic [cdrs_pkg::STEP_W-1:0] step
);
    import cdrs_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = ucode(step_reg);
    assign step = step_reg;

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     cond_hit = 1'b0;
            COND_IN_VALID:  cond_hit = flags.in_valid;
            COND_ZERO:      cond_hit = flags.zero;
            COND_DIV_DONE:  cond_hit = flags.div_done;
            COND_MATCH:     cond_hit = flags.match;
            COND_MULT_MORE: cond_hit = flags.mult_more;
            COND_OUT_FREE:  cond_hit = flags.out_free;
            default:        cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cond_hit)
            step_next = ctrl.target;
        else if (ctrl.hold)
            step_next = step_reg;
        else
            step_next = step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire
